// File: rtl/sfa_pkg.sv
// ----------------------------------------------------------------------------
// sfa_pkg
// Shared codes and control records of the segment fit allocator.
// ----------------------------------------------------------------------------
package sfa_pkg;

	// Field widths of the item ports
	localparam int MODE_W   = 3;
	localparam int PSIZE_W  = 16;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 6;

	// Modes
	localparam logic [MODE_W-1:0] MODE_LOAD  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_FIRST = 3'd1;
	localparam logic [MODE_W-1:0] MODE_BEST  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_WORST = 3'd3;
	localparam logic [MODE_W-1:0] MODE_NEXT  = 3'd4;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// Table update strobes broadcast to every cell
	typedef struct packed {
		logic load;
		logic commit;
		logic ld_used;
	} sfa_wr_t;

endpackage

// File: rtl/sfa_if.sv
// ----------------------------------------------------------------------------
// sfa_in_if / sfa_out_if
// Valid/ready channels carrying request and result items.
// ----------------------------------------------------------------------------
interface sfa_in_if;
	import sfa_pkg::*;
	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [PSIZE_W-1:0]  seg_size;
	logic                seg_allocated;
	modport source (output valid, mode, seg_size, seg_allocated, input ready);
	modport sink   (input valid, mode, seg_size, seg_allocated, output ready);
endinterface

interface sfa_out_if;
	import sfa_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot_index;
	logic [PSIZE_W-1:0]  leftover;
	modport source (output valid, status, slot_index, leftover, input ready);
	modport sink   (input valid, status, slot_index, leftover, output ready);
endinterface

// File: rtl/sfa_cell.sv
// ----------------------------------------------------------------------------
// sfa_cell
// One table entry plus one stage of the candidate chain that sweeps the table.
// ----------------------------------------------------------------------------
module sfa_cell import sfa_pkg::*; #(
	parameter int IW  = 6,
	parameter int CW  = 7,
	parameter int SW  = 16,
	parameter int IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sfa_wr_t           wr,
	input  logic [MODE_W-1:0] mode,
	input  logic [SW-1:0]     req,
	input  logic [SW-1:0]     left,
	input  logic [CW-1:0]     count,
	input  logic [CW-1:0]     pick,
	input  logic [CW-1:0]     start,
	input  logic [SW-1:0]     prev_size,
	input  logic              prev_used,
	output logic [SW-1:0]     size,
	output logic              used,
	input  logic              ci_valid,
	input  logic              ci_found,
	input  logic [IW-1:0]     ci_idx,
	input  logic [SW-1:0]     ci_size,
	input  logic              ci_hfound,
	input  logic [IW-1:0]     ci_hidx,
	input  logic [SW-1:0]     ci_hsize,
	output logic              co_valid,
	output logic              co_found,
	output logic [IW-1:0]     co_idx,
	output logic [SW-1:0]     co_size,
	output logic              co_hfound,
	output logic [IW-1:0]     co_hidx,
	output logic [SW-1:0]     co_hsize
);

	localparam logic [CW-1:0] MY   = CW'(IDX);
	localparam logic [IW-1:0] MYI  = IW'(IDX);

	logic [SW-1:0] size_q;
	logic          used_q;
	logic          fit, take, htake;
	logic [CW-1:0] pick_nx;

	assign size = size_q;
	assign used = used_q;
	assign pick_nx = pick + CW'(1);

	// Local fit test and candidate update
	always_comb begin
		fit   = (MY < count) && !used_q && (size_q >= req);
		take  = 1'b0;
		htake = fit && (MY >= start) && !ci_hfound;
		case (mode)
			MODE_BEST:  take = fit && (!ci_found || size_q < ci_size);
			MODE_WORST: take = fit && (!ci_found || size_q > ci_size);
			default:    take = fit && !ci_found;
		endcase
	end

	// Advance the candidate one cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			co_valid <= 1'b0;
		end else begin
			co_valid <= ci_valid;
		end
	end

	always_ff @(posedge clk) begin
		co_found  <= ci_found || take;
		co_idx    <= take ? MYI : ci_idx;
		co_size   <= take ? size_q : ci_size;
		co_hfound <= ci_hfound || htake;
		co_hidx   <= htake ? MYI : ci_hidx;
		co_hsize  <= htake ? size_q : ci_hsize;
	end

	// Entry update: append, split the chosen hole, or shift down from neighbour
	always_ff @(posedge clk) begin
		if (wr.load && MY == count) begin
			size_q <= req;
			used_q <= wr.ld_used;
		end else if (wr.commit) begin
			if (MY == pick) begin
				size_q <= req;
				used_q <= 1'b1;
			end else if (MY == pick_nx) begin
				size_q <= left;
				used_q <= 1'b0;
			end else if (MY > pick_nx && MY <= count) begin
				size_q <= prev_size;
				used_q <= prev_used;
			end
		end
	end

endmodule

// File: rtl/segment_fit_allocator.sv
// ----------------------------------------------------------------------------
// segment_fit_allocator
// Segment table with first, best, worst and next fit hole allocation.
// ----------------------------------------------------------------------------
// One item at a time. A load, or an item with an unused mode, gives its result
// in the cycle after acceptance. For an allocation, a candidate record travels
// down the row of table cells, one cell per cycle, and picks the hole for the
// chosen policy. The split and shift of the table then happen together, with
// each cell above the split taking its neighbour's entry. The next item is
// accepted in the cycle after the result has been taken.
module segment_fit_allocator import sfa_pkg::*; #(
	parameter int MAX_SEGMENTS = 64,
	parameter int SIZE_BITS    = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	sfa_in_if.sink           in_ch,
	sfa_out_if.source        out_ch
);

	localparam int N  = MAX_SEGMENTS;
	localparam int IW = $clog2(N);
	localparam int CW = $clog2(N + 1);
	localparam int SW = SIZE_BITS;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]          state_q;
	logic [CW-1:0]       count_q;
	logic [IW-1:0]       rover_q;
	logic [MODE_W-1:0]   mode_q;
	logic [SW-1:0]       req_q;
	logic [CW-1:0]       start_q;
	logic                launch_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [SLOT_W-1:0]   res_slot_q;
	logic [PSIZE_W-1:0]  res_left_q;

	logic                accept;
	logic [SW+PSIZE_W-1:0] req_ext;
	logic [SW-1:0]       in_req, req_mux;
	sfa_wr_t             wr;
	logic [SW-1:0]       sz   [N+1];
	logic                us   [N+1];
	logic                cv   [N+1];
	logic                cf   [N+1];
	logic [IW-1:0]       cidx [N+1];
	logic [SW-1:0]       csz  [N+1];
	logic                chf  [N+1];
	logic [IW-1:0]       chidx[N+1];
	logic [SW-1:0]       chsz [N+1];
	logic                hit;
	logic [IW-1:0]       pick;
	logic [SW-1:0]       pick_size;
	logic [SW-1:0]       left;
	logic [SW+PSIZE_W-1:0] left_ext;
	logic                full;

	assign accept  = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);
	assign req_ext = {{SW{1'b0}}, in_ch.seg_size};
	assign in_req  = req_ext[SW-1:0];
	assign req_mux = (state_q == S_IDLE) ? in_req : req_q;
	assign full    = (count_q == CW'(N));

	// Resolve the policy outcome from the end of the chain
	always_comb begin
		if (mode_q == MODE_NEXT && chf[N]) begin
			hit = 1'b1;
			pick = chidx[N];
			pick_size = chsz[N];
		end else begin
			hit = cf[N];
			pick = cidx[N];
			pick_size = csz[N];
		end
		left = pick_size - req_q;
		left_ext = {{PSIZE_W{1'b0}}, left};
	end

	// Table update strobes
	always_comb begin
		wr.load    = accept && in_ch.mode == MODE_LOAD && !full;
		wr.ld_used = in_ch.seg_allocated;
		wr.commit  = state_q == S_SCAN && cv[N] && hit && !full;
	end

	assign sz[0] = '0;
	assign us[0] = 1'b0;
	assign cv[0] = launch_q;
	assign cf[0] = 1'b0;
	assign cidx[0] = '0;
	assign csz[0] = '0;
	assign chf[0] = 1'b0;
	assign chidx[0] = '0;
	assign chsz[0] = '0;

	// Row of table cells
	for (genvar g = 0; g < N; g++) begin : g_cell
		sfa_cell #(.IW(IW), .CW(CW), .SW(SW), .IDX(g)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.wr        (wr),
			.mode      (mode_q),
			.req       (req_mux),
			.left      (left),
			.count     (count_q),
			.pick      (CW'(pick)),
			.start     (start_q),
			.prev_size (sz[g]),
			.prev_used (us[g]),
			.size      (sz[g+1]),
			.used      (us[g+1]),
			.ci_valid  (cv[g]),
			.ci_found  (cf[g]),
			.ci_idx    (cidx[g]),
			.ci_size   (csz[g]),
			.ci_hfound (chf[g]),
			.ci_hidx   (chidx[g]),
			.ci_hsize  (chsz[g]),
			.co_valid  (cv[g+1]),
			.co_found  (cf[g+1]),
			.co_idx    (cidx[g+1]),
			.co_size   (csz[g+1]),
			.co_hfound (chf[g+1]),
			.co_hidx   (chidx[g+1]),
			.co_hsize  (chsz[g+1])
		);
	end

	// Sequencer, table count and rover
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			rover_q  <= '0;
			launch_q <= 1'b0;
		end else begin
			launch_q <= accept && in_ch.mode != MODE_LOAD && in_ch.mode <= MODE_NEXT;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_ch.mode == MODE_LOAD) begin
							if (!full) count_q <= count_q + CW'(1);
							state_q <= S_DONE;
						end else if (in_ch.mode > MODE_NEXT) begin
							state_q <= S_DONE;
						end else begin
							state_q  <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (cv[N]) begin
						state_q <= S_DONE;
						if (wr.commit) begin
							count_q <= count_q + CW'(1);
							if (mode_q == MODE_NEXT) begin
								rover_q <= pick + IW'(1);
							end else if (rover_q > pick && CW'(rover_q) < count_q) begin
								rover_q <= rover_q + IW'(1);
							end
						end
					end
				end
				S_DONE: begin
					if (out_ch.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Hold request fields and form the result
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= in_ch.mode;
			req_q   <= in_req;
			start_q <= (CW'(rover_q) < count_q) ? CW'(rover_q) : '0;
			res_status_q <= (in_ch.mode == MODE_LOAD && full) ? ST_FULL : ST_DONE;
			res_slot_q   <= (in_ch.mode == MODE_LOAD && !full) ? SLOT_W'(count_q) : '0;
			res_left_q   <= '0;
		end else if (state_q == S_SCAN && cv[N]) begin
			if (!hit) begin
				res_status_q <= ST_NOFIT;
			end else if (full) begin
				res_status_q <= ST_FULL;
			end else begin
				res_status_q <= ST_DONE;
				res_slot_q   <= SLOT_W'(pick);
				res_left_q   <= left_ext[PSIZE_W-1:0];
			end
		end
	end

	assign out_ch.valid      = (state_q == S_DONE);
	assign out_ch.status     = res_status_q;
	assign out_ch.slot_index = res_slot_q;
	assign out_ch.leftover   = res_left_q;

endmodule
